// ===== design/tra_pkg.sv =====
// Shared types, constants and controller commands for the texture reflectivity average unit.
package tra_pkg;

	// Default texel limit per texture; the count saturates here.
	localparam int MAX_TEXELS_DEF = 65536;

	// Result precision: unsigned Q1.16, with one integer bit so that one is representable.
	localparam int QW = 17;
	localparam int STEP_W = $clog2(QW);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QW - 1);

	// Channel select codes for the shared divider.
	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_texel;
	} texel_t;

	typedef struct packed {
		logic [QW-1:0] refl_red;
		logic [QW-1:0] refl_green;
		logic [QW-1:0] refl_blue;
	} result_t;

	typedef struct packed {
		logic       accum;
		logic       capture;
		logic       prep_a;
		logic       prep_b;
		logic       div_load;
		logic       div_step;
		logic [1:0] chan;
		logic       store;
		logic       emit;
	} tra_cmd_t;

	typedef struct packed {
		logic out_free;
	} tra_status_t;

endpackage

// ===== design/tra_ctrl.sv =====
// Controller state machine: accumulation, preparation, the per-channel division sequence and the output hand-off.
module tra_ctrl
	import tra_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        texel_valid,
	input  logic        last_texel,
	output logic        texel_stall,
	input  tra_status_t status,
	output tra_cmd_t    cmd
);

	localparam logic [2:0] S_ACC    = 3'd0;
	localparam logic [2:0] S_PREP_A = 3'd1;
	localparam logic [2:0] S_PREP_B = 3'd2;
	localparam logic [2:0] S_LOAD   = 3'd3;
	localparam logic [2:0] S_DIV    = 3'd4;
	localparam logic [2:0] S_EMIT   = 3'd5;

	logic [2:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic [1:0]        chan_q, chan_d;

	always_comb begin
		state_d = state_q;
		step_d = step_q;
		chan_d = chan_q;
		cmd = '0;
		cmd.chan = chan_q;
		texel_stall = 1'b1;
		unique case (state_q)
			S_ACC: begin
				texel_stall = 1'b0;
				if (texel_valid) begin
					cmd.accum = 1'b1;
					if (last_texel) begin
						cmd.capture = 1'b1;
						state_d = S_PREP_A;
					end
				end
			end
			S_PREP_A: begin
				cmd.prep_a = 1'b1;
				state_d = S_PREP_B;
			end
			S_PREP_B: begin
				cmd.prep_b = 1'b1;
				chan_d = CH_RED;
				state_d = S_LOAD;
			end
			S_LOAD: begin
				cmd.div_load = 1'b1;
				step_d = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				step_d = step_q + 1'b1;
				if (step_q == STEP_LAST) begin
					cmd.store = 1'b1;
					if (chan_q == CH_BLUE) begin
						state_d = S_EMIT;
					end else begin
						chan_d = chan_q + 1'b1;
						state_d = S_LOAD;
					end
				end
			end
			S_EMIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d = S_ACC;
				end
			end
			default: begin
				state_d = S_ACC;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_ACC;
			step_q <= '0;
			chan_q <= CH_RED;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			chan_q <= chan_d;
		end
	end

endmodule

// ===== design/tra_dp.sv =====
// Datapath: channel accumulators, final sums, shared restoring divider and the output register.
module tra_dp
	import tra_pkg::*;
#(
	parameter int MAX_TEXELS = MAX_TEXELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  texel_t      texel,
	input  tra_cmd_t    cmd,
	output tra_status_t status,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result
);

	localparam int CW = $clog2(MAX_TEXELS + 1);
	localparam int SW = CW + 8;
	localparam int RW = SW + 1;

	logic [SW-1:0] sum_r_q, sum_g_q, sum_b_q;
	logic [CW-1:0] count_q;
	logic [SW-1:0] add_r, add_g, add_b;
	logic [CW-1:0] add_n;
	logic          room;

	logic [SW-1:0] fin_r_q, fin_g_q, fin_b_q;
	logic [CW-1:0] fin_n_q;
	logic [SW-1:0] smax_q, den_q;
	logic [SW-1:0] max_rg;
	logic          dim_q, zero_q;

	logic [RW-1:0] rem_q, shifted, rem_next;
	logic [SW-1:0] dvs_q;
	logic [QW-1:0] quo_q, quo_next;
	logic          first_q, ge;
	logic [SW-1:0] num_sel;

	logic [QW-1:0] res_r_q, res_g_q, res_b_q;
	logic          out_valid_q;
	result_t       out_q;

	// Texels past the limit are dropped and the count holds.
	assign room = count_q < CW'(MAX_TEXELS);
	assign add_r = room ? sum_r_q + {{(SW-8){1'b0}}, texel.red} : sum_r_q;
	assign add_g = room ? sum_g_q + {{(SW-8){1'b0}}, texel.green} : sum_g_q;
	assign add_b = room ? sum_b_q + {{(SW-8){1'b0}}, texel.blue} : sum_b_q;
	assign add_n = room ? count_q + 1'b1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_r_q <= '0;
			sum_g_q <= '0;
			sum_b_q <= '0;
			count_q <= '0;
		end else if (cmd.accum) begin
			if (cmd.capture) begin
				sum_r_q <= '0;
				sum_g_q <= '0;
				sum_b_q <= '0;
				count_q <= '0;
			end else begin
				sum_r_q <= add_r;
				sum_g_q <= add_g;
				sum_b_q <= add_b;
				count_q <= add_n;
			end
		end
	end

	assign max_rg = (fin_g_q > fin_r_q) ? fin_g_q : fin_r_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			fin_r_q <= add_r;
			fin_g_q <= add_g;
			fin_b_q <= add_b;
			fin_n_q <= add_n;
		end
		if (cmd.prep_a) begin
			smax_q <= (fin_b_q > max_rg) ? fin_b_q : max_rg;
			// 255 * n as a shift and a subtract.
			den_q <= {fin_n_q, 8'd0} - {8'd0, fin_n_q};
		end
		if (cmd.prep_b) begin
			dim_q <= {smax_q, 1'b0} < {1'b0, den_q};
			zero_q <= (smax_q == '0) || (fin_n_q == '0);
		end
	end

	always_comb begin
		case (cmd.chan)
			CH_RED:   num_sel = fin_r_q;
			CH_GREEN: num_sel = fin_g_q;
			default:  num_sel = fin_b_q;
		endcase
	end

	// One quotient bit per cycle; the first step takes the integer bit without a shift.
	// The numerator never reaches twice the divisor, so the remainder stays below the divisor.
	assign shifted = first_q ? rem_q : {rem_q[RW-2:0], 1'b0};
	assign ge = shifted >= {1'b0, dvs_q};
	assign rem_next = ge ? shifted - {1'b0, dvs_q} : shifted;
	assign quo_next = {quo_q[QW-2:0], ge};

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q <= dim_q ? {num_sel, 1'b0} : {1'b0, num_sel};
			dvs_q <= dim_q ? den_q : smax_q;
			quo_q <= '0;
			first_q <= 1'b1;
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
			first_q <= 1'b0;
		end
		if (cmd.store) begin
			case (cmd.chan)
				CH_RED:   res_r_q <= zero_q ? '0 : quo_next;
				CH_GREEN: res_g_q <= zero_q ? '0 : quo_next;
				default:  res_b_q <= zero_q ? '0 : quo_next;
			endcase
		end
	end

	assign status.out_free = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.refl_red <= res_r_q;
			out_q.refl_green <= res_g_q;
			out_q.refl_blue <= res_b_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result = out_q;

endmodule

// ===== design/texture_reflectivity_average_unit.sv =====
// Top level of the texture reflectivity average unit: controller plus datapath.
//
//   Channel  Payload   Handshake                   Direction
//   texel    texel_t   texel_valid / texel_stall   into the unit
//   result   result_t  result_valid / result_stall out of the unit
//
// Texels without the last mark are accepted back to back while the unit accumulates.
// After a last texel the input stalls through the preparation states PREP_A and PREP_B,
// then the one shared restoring divider loads and runs for each of the three channels,
// then the output register is loaded once any prior result is no longer stalled.
// The output register lets the next texture accumulate while a result waits.
// Reset clears the sums, the count, the control state and the output valid flag.
module texture_reflectivity_average_unit
	import tra_pkg::*;
#(
	parameter int MAX_TEXELS = MAX_TEXELS_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    texel_valid,
	output logic    texel_stall,
	input  texel_t  texel,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	tra_cmd_t    cmd;
	tra_status_t status;

	tra_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.texel_valid (texel_valid),
		.last_texel  (texel.last_texel),
		.texel_stall (texel_stall),
		.status      (status),
		.cmd         (cmd)
	);

	tra_dp #(
		.MAX_TEXELS (MAX_TEXELS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.texel        (texel),
		.cmd          (cmd),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
